// ----- rtl/core/pal_pkg.sv -----
package pal_pkg;

  // Store geometry
  localparam int unsigned DEPTH  = 128;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CAP_W  = 8;

  // Largest limit the 8-bit register can express against the store depth
  localparam int unsigned LIM_MAX = (DEPTH > 255) ? 255 : DEPTH;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

  // Read gather tree: first level ORs GRP cells, second level ORs the groups
  localparam int unsigned GRP  = 16;
  localparam int unsigned NGRP = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // What every cell does in the update cycle
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER
  } state_e;

  typedef struct packed {
    cmd_e                     command;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    status_e                  status;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;
  } out_word_t;

  // Broadcast to the cell row
  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  tgt;
    logic [WORD_W-1:0] wdata;
  } cell_ctl_t;

endpackage

// ----- rtl/core/pal_cell.sv -----
module pal_cell (
  input  logic                      clk,
  input  logic [pal_pkg::IDX_W-1:0]  idx,
  input  pal_pkg::cell_ctl_t        ctl,
  input  logic [pal_pkg::WORD_W-1:0] left_word,
  input  logic [pal_pkg::WORD_W-1:0] right_word,
  output logic [pal_pkg::WORD_W-1:0] word,
  output logic [pal_pkg::WORD_W-1:0] sel_word
);
  import pal_pkg::*;

  logic [WORD_W-1:0] word_next;

  // Shift/write decision from own index vs. target position
  always_comb begin
    word_next = word;
    unique case (ctl.op)
      OP_NONE: begin
        word_next = word;
      end
      OP_WRITE: begin
        if (idx == ctl.tgt) word_next = ctl.wdata;
      end
      OP_INSERT: begin
        if (idx == ctl.tgt)     word_next = ctl.wdata;
        else if (idx > ctl.tgt) word_next = left_word;
      end
      OP_REMOVE: begin
        if (idx >= ctl.tgt) word_next = right_word;
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Masked word for the read gather
  assign sel_word = (idx == ctl.tgt) ? word : '0;

endmodule

// ----- rtl/core/pal_read_tree.sv -----
module pal_read_tree (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pal_pkg::WORD_W-1:0] words [pal_pkg::DEPTH],
  output logic [pal_pkg::WORD_W-1:0] rd_word
);
  import pal_pkg::*;

  logic [WORD_W-1:0] grp      [NGRP];
  logic [WORD_W-1:0] grp_next [NGRP];

  // First level: OR each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) grp_next[g] = grp_next[g] | words[g * GRP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NGRP; g++) grp[g] <= grp_next[g];
    end
  end

  // Second level: OR of the registered groups
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) rd_word = rd_word | grp[g];
  end

endmodule

// ----- rtl/core/positional_array_list.sv -----
// Channel   Ports                          Handshake
// -------   -----------------------------  ------------------------------------
// command   in_word                        taken when start && !busy
// result    out_word                       valid for the one cycle done is high
// config    cfg_data                       capacity limit written when cfg_we
//
// Once accepted, a command goes through these steps before its word is taken:
// the EXEC state checks it while the cell row shifts or writes and the read
// gather catches its first level, the GATHER state finishes the read gather
// and registers the word, and the done cycle follows. busy is high for the
// first two only, so a new command can be taken in the done cycle at the earliest.
// Synchronous reset empties the list and sets the limit to 128; cell contents
// are not cleared. The receiver cannot stall: done pulses once per command.
module positional_array_list (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  pal_pkg::in_word_t        in_word,
  output logic                     done,
  output pal_pkg::out_word_t       out_word,
  input  logic                     cfg_we,
  input  logic [pal_pkg::CAP_W-1:0] cfg_data
);
  import pal_pkg::*;

  state_e            state, state_next;
  in_word_t          cmd_q;
  logic [CNT_W-1:0]  count, count_next;
  logic [CAP_W-1:0]  cap;
  status_e           st_q, st_next;
  logic              rd_ok;
  out_word_t         res;
  logic              done_q;

  logic [CAP_W-1:0]  lim;
  logic [CNT_W:0]    count_p1;
  cell_ctl_t         ctl;
  logic              gather_en;
  logic [WORD_W-1:0] cell_word [DEPTH];
  logic [WORD_W-1:0] sel_word  [DEPTH];
  logic [WORD_W-1:0] rd_word;

  // Limit in effect, saturated at the store depth
  assign lim      = (cap > CAP_W'(LIM_MAX)) ? CAP_W'(LIM_MAX) : cap;
  assign count_p1 = {1'b0, count} + (CNT_W+1)'(1);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, command checks, cell broadcast
  always_comb begin
    state_next = state;
    st_next    = ST_OK;
    count_next = count;
    ctl.op     = OP_NONE;
    ctl.tgt    = IDX_W'(cmd_q.position - POS_W'(1));
    ctl.wdata  = $unsigned(cmd_q.value);
    gather_en  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        gather_en  = 1'b1;
        state_next = S_GATHER;
        if (cmd_q.command == CMD_INSERT) begin
          if (count >= lim) begin
            st_next = ST_FULL;
          end else if (cmd_q.position == '0 || {1'b0, cmd_q.position} > count_p1) begin
            st_next = ST_BAD_POS;
          end else begin
            ctl.op     = OP_INSERT;
            count_next = count + CNT_W'(1);
          end
        end else if (cmd_q.position == '0 || cmd_q.position > count) begin
          st_next = ST_BAD_POS;
        end else begin
          unique case (cmd_q.command)
            CMD_WRITE:  ctl.op = OP_WRITE;
            CMD_REMOVE: begin
              ctl.op     = OP_REMOVE;
              count_next = count - CNT_W'(1);
            end
            default:    ctl.op = OP_NONE;
          endcase
        end
      end
      S_GATHER: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // Command capture and per-command bookkeeping
  always_ff @(posedge clk) begin
    if (start && !busy) cmd_q <= in_word;
    if (state == S_EXEC) begin
      st_q  <= st_next;
      rd_ok <= (cmd_q.command == CMD_READ) && (st_next == ST_OK);
    end
    if (state == S_GATHER) begin
      res.read_value  <= rd_ok ? $signed(rd_word) : '0;
      res.status      <= st_q;
      res.entry_count <= count;
      res.is_empty    <= (count == '0);
      res.is_full     <= (count >= lim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done_q <= 1'b0;
    end else begin
      count  <= count_next;
      done_q <= (state == S_GATHER);
    end
  end

  assign done     = done_q;
  assign out_word = res;

  // Cell row, each cell linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end
    pal_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .sel_word   (sel_word[i])
    );
  end

  pal_read_tree u_read_tree (
    .clk     (clk),
    .en      (gather_en),
    .words   (sel_word),
    .rd_word (rd_word)
  );

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("entry count beyond store depth");

  a_done_after_gather: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_GATHER)
    else $error("done without a finished command");

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted command gave no word on time");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (count == $past(count) || count == $past(count) + CNT_W'(1)
                           || count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");
`endif

endmodule
